// File: rtl/core/rbs_pkg.sv
`default_nettype none

package rbs_pkg;

	// Device slots and derived widths.
	localparam int DEVICES    = 8;
	localparam int DEV_W      = $clog2(DEVICES);
	localparam int CNT_W      = $clog2(DEVICES + 1);
	localparam int DEV_IDX_W  = 8;

	// Field widths.
	localparam int BASE_W     = 32;
	localparam int PCT_W      = 7;
	localparam int RND_W      = 31;
	localparam int RETRY_W    = 8;
	localparam int DELAY_W    = 64;
	localparam int PCOUNT_W   = 4;
	localparam int SHIFT_W    = $clog2(DELAY_W);

	// Jitter bound arithmetic.
	localparam int PERCENT_SCALE = 100;
	localparam int PROD_W        = DELAY_W + PCT_W;
	localparam int REM_W         = $clog2(PERCENT_SCALE);
	localparam int QDIV_W        = REM_W + RND_W;
	localparam int STEP_W        = $clog2(QDIV_W);
	// A product at or above this limit gives a bound that no random word can reach.
	localparam logic [PROD_W-1:0] JIT_LIMIT = PROD_W'(PERCENT_SCALE) << RND_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_DELAY  = 2'd0,
		REG_JITTER_PCT  = 2'd1,
		REG_TEARING     = 2'd2
	} reg_idx_t;

	typedef enum logic {
		CMD_SCHEDULE = 1'b0,
		CMD_COMPLETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_PENDING  = 2'd1,
		ST_RANGE    = 2'd2,
		ST_TEARDOWN = 2'd3
	} status_t;

	typedef struct packed {
		logic                 command;
		logic [DEV_IDX_W-1:0] device_index;
		logic [RETRY_W-1:0]   retry_count;
		logic [RND_W-1:0]     random_value;
	} rbs_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                scheduled;
		logic [DELAY_W-1:0]  backoff_ms;
		logic [PCOUNT_W-1:0] pending_count;
	} rbs_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/retry_backoff_scheduler.sv
`default_nettype none

// Retry backoff scheduler: one pending-retry flag per device slot and a count of set flags.
// Requests arrive on req_valid/req_stall/req_data and one response per request leaves on
// rsp_valid/rsp_stall/rsp_data; a transaction completes when valid is high and stall is low.
// The user must write registers through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block does not enforce this. One request is worked on at a time; req_stall is
// high from acceptance until the response is loaded into the output register. A completion,
// a rejected or an already-pending request goes straight to the done state; a schedule whose
// jitter bound exceeds any random word passes through shift, multiply, prepare and add;
// other schedules add, between prepare and add, a 38-step bit-serial divide by one hundred
// followed by a 31-step bit-serial modulo of the random word. The next request is taken the
// cycle after the response is loaded, so a new schedule cannot start before the previous
// response has been loaded.
// A response waits in the output register while rsp_stall is high; the next request is
// still accepted, and its response is held back until the register frees up.
// Reset clears all pending flags, the count and the registers.
module retry_backoff_scheduler (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_stall,
	input  rbs_pkg::rbs_req_t             req_data,
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output rbs_pkg::rbs_rsp_t             rsp_data,
	input  wire                           cfg_we,
	input  wire [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [rbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHIFT,
		S_MUL,
		S_PREP,
		S_DIV,
		S_MPREP,
		S_MOD,
		S_ADD,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [rbs_pkg::BASE_W-1:0] base_q;
	logic [rbs_pkg::PCT_W-1:0]  jit_pct_q;
	logic                       tearing_q;

	// Device bookkeeping.
	logic [rbs_pkg::DEVICES-1:0] flags_q;
	logic [rbs_pkg::CNT_W-1:0]   total_q;

	// Per-request working registers.
	logic [1:0]                   status_q;
	logic                         sched_q;
	logic [rbs_pkg::RETRY_W-1:0]  retry_q;
	logic [rbs_pkg::RND_W-1:0]    rnd_q;
	logic [rbs_pkg::DELAY_W-1:0]  d_q;
	logic [rbs_pkg::DELAY_W-1:0]  delay_q;
	logic [rbs_pkg::PROD_W-1:0]   prod_q;
	logic                         large_q;
	logic [rbs_pkg::QDIV_W-1:0]   dvd_q;
	logic [rbs_pkg::REM_W-1:0]    drem_q;
	logic [rbs_pkg::RND_W:0]      div_q;
	logic [rbs_pkg::RND_W:0]      mrem_q;
	logic [rbs_pkg::RND_W-1:0]    rsh_q;
	logic [rbs_pkg::STEP_W-1:0]   step_q;

	logic                         rsp_valid_q;
	rbs_pkg::rbs_rsp_t            rsp_q;

	// Combinational helpers.
	logic                               req_acc;
	logic                               dev_ok;
	logic [rbs_pkg::DEV_W-1:0]          dev_sel;
	logic                               dev_flag;
	rbs_pkg::status_t                   acc_status;
	logic                               acc_set;
	logic                               acc_clr;
	logic [rbs_pkg::RETRY_W-1:0]        shamt;
	logic [rbs_pkg::BASE_W+rbs_pkg::DELAY_W-1:0] ext;
	logic                               shift_sat;
	logic [rbs_pkg::DELAY_W-1:0]        d_next;
	logic [rbs_pkg::PROD_W-1:0]         prod;
	logic [rbs_pkg::REM_W:0]            dt;
	logic                               dge;
	logic [rbs_pkg::RND_W+1:0]          mt;
	logic                               mge;
	logic [rbs_pkg::RND_W:0]            jit;
	logic [rbs_pkg::DELAY_W:0]          sum;
	logic                               rsp_load;

	assign req_acc  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	assign dev_ok   = req_data.device_index < rbs_pkg::DEV_IDX_W'(rbs_pkg::DEVICES);
	assign dev_sel  = req_data.device_index[rbs_pkg::DEV_W-1:0];
	assign dev_flag = flags_q[dev_sel];

	// Outcome of an accepted request, decided from the flags before they change.
	always_comb begin
		acc_status = rbs_pkg::ST_DONE;
		acc_set    = 1'b0;
		acc_clr    = 1'b0;
		if (!dev_ok) begin
			acc_status = rbs_pkg::ST_RANGE;
		end else if (req_data.command == rbs_pkg::CMD_COMPLETE) begin
			acc_clr = dev_flag;
		end else if (tearing_q) begin
			acc_status = rbs_pkg::ST_TEARDOWN;
		end else if (dev_flag) begin
			acc_status = rbs_pkg::ST_PENDING;
		end else begin
			acc_set = 1'b1;
		end
	end

	// Doubling by retry_count-1 as one shift; anything that reaches the top word saturates.
	always_comb begin
		shamt     = (retry_q > rbs_pkg::RETRY_W'(1)) ? retry_q - rbs_pkg::RETRY_W'(1)
			: '0;
		ext       = {{rbs_pkg::DELAY_W{1'b0}}, base_q} << shamt[rbs_pkg::SHIFT_W-1:0];
		shift_sat = (shamt >= rbs_pkg::RETRY_W'(rbs_pkg::DELAY_W)) ? (base_q != '0)
			: (|ext[rbs_pkg::BASE_W+rbs_pkg::DELAY_W-1:rbs_pkg::DELAY_W]);
		d_next    = shift_sat ? '1 : ext[rbs_pkg::DELAY_W-1:0];
	end

	assign prod = rbs_pkg::PROD_W'(d_q) * rbs_pkg::PROD_W'(jit_pct_q);

	// One quotient bit of the divide by one hundred.
	always_comb begin
		dt  = {drem_q, dvd_q[rbs_pkg::QDIV_W-1]};
		dge = dt >= (rbs_pkg::REM_W+1)'(rbs_pkg::PERCENT_SCALE);
	end

	// One step of the restoring modulo of the random word by bound+1.
	always_comb begin
		mt  = {mrem_q, rsh_q[rbs_pkg::RND_W-1]};
		mge = mt >= {1'b0, div_q};
	end

	always_comb begin
		jit = large_q ? {1'b0, rnd_q} : mrem_q;
		sum = {1'b0, d_q} + (rbs_pkg::DELAY_W+1)'(jit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			jit_pct_q <= '0;
			tearing_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rbs_pkg::REG_BASE_DELAY: base_q    <= cfg_data[rbs_pkg::BASE_W-1:0];
				rbs_pkg::REG_JITTER_PCT: jit_pct_q <= cfg_data[rbs_pkg::PCT_W-1:0];
				rbs_pkg::REG_TEARING:    tearing_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			flags_q     <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			status_q    <= '0;
			sched_q     <= 1'b0;
			retry_q     <= '0;
			rnd_q       <= '0;
			d_q         <= '0;
			delay_q     <= '0;
			prod_q      <= '0;
			dvd_q       <= '0;
			drem_q      <= '0;
			div_q       <= '0;
			mrem_q      <= '0;
			rsh_q       <= '0;
			step_q      <= '0;
			large_q     <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						status_q <= acc_status;
						sched_q  <= acc_set;
						delay_q  <= '0;
						retry_q  <= req_data.retry_count;
						rnd_q    <= req_data.random_value;
						state_q  <= acc_set ? S_SHIFT : S_DONE;
						if (acc_set) begin
							flags_q[dev_sel] <= 1'b1;
							total_q          <= total_q + rbs_pkg::CNT_W'(1);
						end else if (acc_clr) begin
							flags_q[dev_sel] <= 1'b0;
							total_q          <= total_q - rbs_pkg::CNT_W'(1);
						end
					end
				end
				S_SHIFT: begin
					d_q     <= d_next;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= prod;
					state_q <= S_PREP;
				end
				S_PREP: begin
					large_q <= prod_q >= rbs_pkg::JIT_LIMIT;
					dvd_q   <= prod_q[rbs_pkg::QDIV_W-1:0];
					drem_q  <= '0;
					step_q  <= rbs_pkg::STEP_W'(rbs_pkg::QDIV_W - 1);
					state_q <= (prod_q >= rbs_pkg::JIT_LIMIT) ? S_ADD : S_DIV;
				end
				S_DIV: begin
					drem_q <= dge ? rbs_pkg::REM_W'(dt - (rbs_pkg::REM_W+1)'(rbs_pkg::PERCENT_SCALE))
						: dt[rbs_pkg::REM_W-1:0];
					dvd_q  <= {dvd_q[rbs_pkg::QDIV_W-2:0], dge};
					step_q <= step_q - rbs_pkg::STEP_W'(1);
					if (step_q == '0) begin
						state_q <= S_MPREP;
					end
				end
				S_MPREP: begin
					// The quotient fits the random word's width here, so bound+1 fits one more bit.
					div_q   <= {1'b0, dvd_q[rbs_pkg::RND_W-1:0]} + (rbs_pkg::RND_W+1)'(1);
					mrem_q  <= '0;
					rsh_q   <= rnd_q;
					step_q  <= rbs_pkg::STEP_W'(rbs_pkg::RND_W - 1);
					state_q <= S_MOD;
				end
				S_MOD: begin
					mrem_q <= mge ? (rbs_pkg::RND_W+1)'(mt - {1'b0, div_q})
						: mt[rbs_pkg::RND_W:0];
					rsh_q  <= {rsh_q[rbs_pkg::RND_W-2:0], 1'b0};
					step_q <= step_q - rbs_pkg::STEP_W'(1);
					if (step_q == '0) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					delay_q <= sum[rbs_pkg::DELAY_W] ? '1 : sum[rbs_pkg::DELAY_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_valid_q           <= 1'b1;
						rsp_q.status          <= status_q;
						rsp_q.scheduled       <= sched_q;
						rsp_q.backoff_ms      <= delay_q;
						rsp_q.pending_count   <= rbs_pkg::PCOUNT_W'(total_q);
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_count_matches_flags;
		@(posedge clk) disable iff (!arst_n)
			total_q == rbs_pkg::CNT_W'($countones(flags_q));
	endproperty
	a_count_matches_flags: assert property (p_count_matches_flags)
		else $error("pending count differs from the number of set flags");

	property p_sched_status;
		@(posedge clk) disable iff (!arst_n)
			rsp_valid_q && rsp_q.scheduled |-> rsp_q.status == rbs_pkg::ST_DONE;
	endproperty
	a_sched_status: assert property (p_sched_status)
		else $error("new retry reported with a non-done status");

	property p_no_task_no_delay;
		@(posedge clk) disable iff (!arst_n)
			rsp_valid_q && !rsp_q.scheduled |-> rsp_q.backoff_ms == '0;
	endproperty
	a_no_task_no_delay: assert property (p_no_task_no_delay)
		else $error("delay reported without a new retry");

	property p_div_rem_range;
		@(posedge clk) disable iff (!arst_n)
			state_q == S_DIV |-> drem_q < rbs_pkg::REM_W'(rbs_pkg::PERCENT_SCALE);
	endproperty
	a_div_rem_range: assert property (p_div_rem_range)
		else $error("divide-by-hundred remainder out of range");

	property p_mod_rem_range;
		@(posedge clk) disable iff (!arst_n)
			state_q == S_MOD |-> mrem_q < div_q;
	endproperty
	a_mod_rem_range: assert property (p_mod_rem_range)
		else $error("jitter remainder not below its divisor");

endmodule

`default_nettype wire

// File: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rbs_pkg::DELAY_W-1:0] ALL_ONES = '1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	rbs_pkg::rbs_req_t              req_data = '0;
	logic                           rsp_valid;
	logic                           rsp_stall = 1'b0;
	rbs_pkg::rbs_rsp_t              rsp_data;
	logic                           cfg_we = 1'b0;
	logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted block state and register copies.
	bit                             pend_flag [rbs_pkg::DEVICES];
	logic [rbs_pkg::PCOUNT_W-1:0]   pend_total = '0;
	logic [rbs_pkg::BASE_W-1:0]     cur_base = '0;
	logic [rbs_pkg::PCT_W-1:0]      cur_pct = '0;
	logic                           cur_teardown = 1'b0;

	rbs_pkg::rbs_rsp_t              expected_rsp_q [$];
	int                             mismatches = 0;
	int                             cycle_count = 0;
	bit                             quiet_mode = 1'b0;
	int                             holds_asked = 0;
	int                             holds_done = 0;
	int                             hold_left = 0;

	retry_backoff_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [rbs_pkg::DELAY_W-1:0] add_capped(
			input logic [rbs_pkg::DELAY_W-1:0] a,
			input logic [rbs_pkg::DELAY_W-1:0] b);
		logic [rbs_pkg::DELAY_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[rbs_pkg::DELAY_W] ? ALL_ONES : sum[rbs_pkg::DELAY_W-1:0];
	endfunction

	function automatic logic [rbs_pkg::DELAY_W-1:0] backoff_delay_for(
			input logic [rbs_pkg::RETRY_W-1:0] retries,
			input logic [rbs_pkg::RND_W-1:0] rnd);
		logic [rbs_pkg::DELAY_W-1:0] d;
		logic [rbs_pkg::DELAY_W-1:0] q;
		logic [rbs_pkg::DELAY_W-1:0] r;
		logic [rbs_pkg::DELAY_W-1:0] pct;
		logic [rbs_pkg::DELAY_W-1:0] bound;
		logic [rbs_pkg::DELAY_W-1:0] jit;
		d = {32'b0, cur_base};
		pct = {57'b0, cur_pct};
		for (int i = 1; i < retries; i++) begin
			if (d > ALL_ONES / 2) begin
				d = ALL_ONES;
				break;
			end
			d = d << 1;
		end
		if (d == ALL_ONES || cur_pct == 0)
			return d;
		// Split the delay by one hundred so that delay * percent cannot overflow.
		q = d / 64'd100;
		r = ((d % 64'd100) * pct) / 64'd100;
		if (q > ALL_ONES / pct)
			bound = ALL_ONES;
		else
			bound = add_capped(q * pct, r);
		if (bound == 0)
			return d;
		jit = (bound == ALL_ONES) ? {33'b0, rnd} : {33'b0, rnd} % (bound + 64'd1);
		return add_capped(d, jit);
	endfunction

	function automatic rbs_pkg::rbs_rsp_t schedule_outcome(input rbs_pkg::rbs_req_t rq);
		rbs_pkg::rbs_rsp_t rs;
		logic [rbs_pkg::DEV_W-1:0] slot;
		rs = '0;
		rs.status = rbs_pkg::ST_DONE;
		slot = rq.device_index[rbs_pkg::DEV_W-1:0];
		if (rq.device_index >= rbs_pkg::DEVICES) begin
			rs.status = rbs_pkg::ST_RANGE;
		end else if (rq.command == rbs_pkg::CMD_COMPLETE) begin
			if (pend_flag[slot]) begin
				pend_flag[slot] = 1'b0;
				pend_total = pend_total - 1'b1;
			end
		end else if (cur_teardown) begin
			rs.status = rbs_pkg::ST_TEARDOWN;
		end else if (pend_flag[slot]) begin
			rs.status = rbs_pkg::ST_PENDING;
		end else begin
			pend_flag[slot] = 1'b1;
			pend_total = pend_total + 1'b1;
			rs.scheduled = 1'b1;
			rs.backoff_ms = backoff_delay_for(rq.retry_count, rq.random_value);
		end
		rs.pending_count = pend_total;
		return rs;
	endfunction

	function automatic void check_field(input string what,
			input logic [rbs_pkg::DELAY_W-1:0] want,
			input logic [rbs_pkg::DELAY_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Response side: random stalls, long hold-offs on request, and the checker.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !quiet_mode && ($urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin : check_proc
		rbs_pkg::rbs_rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: response expected none, got %0h", $time, rsp_data);
				mismatches++;
			end else begin
				want = expected_rsp_q.pop_front();
				check_field("status", want.status, rsp_data.status);
				check_field("scheduled", want.scheduled, rsp_data.scheduled);
				check_field("backoff_ms", want.backoff_ms, rsp_data.backoff_ms);
				check_field("pending_count", want.pending_count, rsp_data.pending_count);
			end
		end
	end

	task automatic send_item(input rbs_pkg::rbs_req_t rq);
		if (!quiet_mode && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_data <= rq;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_rsp_q.push_back(schedule_outcome(rq));
	endtask

	task automatic send_cmd(input rbs_pkg::cmd_t c, input int dev, input int cnt,
			input logic [rbs_pkg::RND_W-1:0] rnd);
		rbs_pkg::rbs_req_t rq;
		rq.command = c;
		rq.device_index = rbs_pkg::DEV_IDX_W'(dev);
		rq.retry_count = rbs_pkg::RETRY_W'(cnt);
		rq.random_value = rnd;
		send_item(rq);
	endtask

	function automatic rbs_pkg::rbs_req_t random_item();
		rbs_pkg::rbs_req_t rq;
		rq.command = ($urandom_range(99) < 45) ? rbs_pkg::CMD_COMPLETE : rbs_pkg::CMD_SCHEDULE;
		rq.device_index = ($urandom_range(99) < 85)
				? rbs_pkg::DEV_IDX_W'($urandom_range(rbs_pkg::DEVICES - 1))
				: rbs_pkg::DEV_IDX_W'($urandom_range(255));
		rq.retry_count = $urandom_range(1) ? rbs_pkg::RETRY_W'($urandom_range(40))
				: rbs_pkg::RETRY_W'($urandom_range(255));
		rq.random_value = rbs_pkg::RND_W'($urandom);
		return rq;
	endfunction

	task automatic send_random(input int n);
		repeat (n) send_item(random_item());
	endtask

	// Stop offering and wait until every predicted response has been seen.
	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rsp_q.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input rbs_pkg::reg_idx_t idx,
			input logic [rbs_pkg::CFG_DATA_W-1:0] val);
		drain_responses();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rbs_pkg::REG_BASE_DELAY: cur_base = val;
			rbs_pkg::REG_JITTER_PCT: cur_pct = val[rbs_pkg::PCT_W-1:0];
			rbs_pkg::REG_TEARING: cur_teardown = val[0];
			default: ;
		endcase
	endtask

	task automatic test_reset_values();
		send_cmd(rbs_pkg::CMD_SCHEDULE, 0, 0, 31'h1234_5678);
		send_cmd(rbs_pkg::CMD_COMPLETE, 0, 0, '0);
	endtask

	task automatic test_backoff_extremes();
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'hFFFF_FFFF);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd100);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 1, 1, 31'h7FFF_FFFF);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 2, 255, 31'h0);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 3, 33, 31'h7FFF_FFFF);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 4, 0, 31'h5555_5555);
		// At this percentage the jitter bound exceeds any random word and the random word is used as is.
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd127);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 5, 32, 31'h2AAA_AAAA);
		// A bound that rounds down to zero adds no jitter.
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'd50);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd1);
		send_cmd(rbs_pkg::CMD_COMPLETE, 1, 0, '0);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 1, 1, 31'h7FFF_FFFF);
	endtask

	task automatic test_rejections();
		send_cmd(rbs_pkg::CMD_SCHEDULE, 1, 7, 31'h1);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 255, 3, 31'h7FFF_FFFF);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 8, 3, 31'h0);
		send_cmd(rbs_pkg::CMD_COMPLETE, 128, 0, '0);
		send_cmd(rbs_pkg::CMD_COMPLETE, 6, 0, '0);
		send_cmd(rbs_pkg::CMD_COMPLETE, 1, 0, '0);
	endtask

	task automatic test_teardown();
		write_reg(rbs_pkg::REG_TEARING, 32'd1);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 6, 2, 31'h3);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 2, 2, 31'h3);
		send_cmd(rbs_pkg::CMD_SCHEDULE, 200, 2, 31'h3);
		send_cmd(rbs_pkg::CMD_COMPLETE, 2, 0, '0);
		write_reg(rbs_pkg::REG_TEARING, 32'd0);
	endtask

	task automatic test_full_table();
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'd3);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd0);
		for (int d = 0; d < rbs_pkg::DEVICES; d++)
			if (!pend_flag[d])
				send_cmd(rbs_pkg::CMD_SCHEDULE, d, d + 2, rbs_pkg::RND_W'($urandom));
	endtask

	task automatic test_output_holdoff();
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'd1000);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd10);
		holds_asked++;
		send_random(40);
	endtask

	task automatic test_sender_pause();
		send_random(15);
		drain_responses();
		send_random(15);
	endtask

	task automatic test_random_settings();
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'hFFFF_FFFF);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd100);
		send_random(60);
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'd0);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd50);
		send_random(50);
		write_reg(rbs_pkg::REG_BASE_DELAY, 32'd1);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd127);
		send_random(50);
		// Unused upper bits of the write data must be ignored.
		quiet_mode = 1'b1;
		write_reg(rbs_pkg::REG_BASE_DELAY, $urandom);
		write_reg(rbs_pkg::REG_JITTER_PCT, $urandom);
		write_reg(rbs_pkg::REG_TEARING, $urandom & 32'hFFFF_FFFE);
		send_random(70);
		quiet_mode = 1'b0;
		write_reg(rbs_pkg::REG_BASE_DELAY, $urandom_range(1, 5000));
		write_reg(rbs_pkg::REG_JITTER_PCT, $urandom_range(100));
		send_random(60);
		write_reg(rbs_pkg::REG_TEARING, 32'd1);
		send_random(30);
		write_reg(rbs_pkg::REG_TEARING, 32'd0);
		write_reg(rbs_pkg::REG_BASE_DELAY, $urandom);
		write_reg(rbs_pkg::REG_JITTER_PCT, 32'd0);
		send_random(40);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_backoff_extremes();
		test_rejections();
		test_teardown();
		test_full_table();
		test_output_holdoff();
		test_sender_pause();
		test_random_settings();
		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsp_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
